>>> src/bpq_pkg.sv
`default_nettype none
package bpq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT_SORTED = 2'd0,
        OP_APPEND        = 2'd1,
        OP_REMOVE_FRONT  = 2'd2,
        OP_REMOVE_MIN    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_SORTED = 2'd1,
        CELL_APPEND = 2'd2,
        CELL_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_op                operation;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] removed_value;
        logic [3:0]         removed_position;
        logic [4:0]         occupancy;
    } t_out_item;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] value;
    } t_cell_ctl;

    typedef struct packed {
        logic               valid;
        logic               none;
        logic signed [31:0] value;
    } t_tok;

    localparam int unsigned CAP_W         = 5;
    localparam logic [4:0]  CAPACITY_RST  = 5'd16;
    localparam logic        REG_CAPACITY  = 1'b0;

endpackage
`default_nettype wire

>>> src/bounded_priority_queue_core.sv
`default_nettype none
// Channel   Direction  Handshake                        Payload
// in        input      i_in_valid / o_in_ready          i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_ready        o_out_item (t_out_item)
// config    input      psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// Insert, append and remove-front results are registered; each shows in the cycle after the item is accepted.
// Remove-min: the running minimum walks the cell chain, one cell per cycle, and
// the removal then closes the gap.
// One item is in flight at a time; a waiting result holds until it is taken.
// Reset clears the entry count and sets capacity to 16; entry contents are not reset.
module bounded_priority_queue_core #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire bpq_pkg::t_in_item     i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output bpq_pkg::t_out_item         o_out_item,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import bpq_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned WW = (CW > CAP_W) ? CW : CAP_W;
    localparam int unsigned PW = (IW > 4) ? IW : 4;

    t_state             r_state;
    t_state             n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [4:0]         r_capacity;
    logic               r_out_valid;
    t_out_item          r_out_item;
    t_out_item          n_out_item;
    logic               out_load;

    t_cell_ctl          cell_ctl;
    logic [IW-1:0]      cell_pos;
    t_tok               tok_start;

    logic signed [31:0] w_entry   [DEPTH];
    logic               w_s       [DEPTH];
    t_tok               w_tok     [DEPTH];
    logic [IW-1:0]      w_tok_idx [DEPTH];

    logic               accept;
    logic               is_insert;
    logic               full;
    logic               empty;
    logic               scan_done;
    logic [WW-1:0]      count_ext;
    logic [WW-1:0]      cap_ext;
    logic [WW-1:0]      occ_ext;
    logic [PW-1:0]      pos_ext;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {27'd0, r_capacity} : 32'd0;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign is_insert   = (i_in_item.operation == OP_INSERT_SORTED)
                      || (i_in_item.operation == OP_APPEND);
    assign count_ext   = WW'(r_count);
    assign cap_ext     = WW'(r_capacity);
    assign full        = (r_count >= CW'(DEPTH)) || (count_ext >= cap_ext);
    assign empty       = (r_count == '0);
    assign scan_done   = w_tok[DEPTH-1].valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_in_item.operation == OP_REMOVE_MIN) && !empty) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cell_ctl.op    = CELL_HOLD;
        cell_ctl.value = i_in_item.value;
        cell_pos       = '0;
        tok_start.valid = 1'b0;
        tok_start.none  = 1'b1;
        tok_start.value = '0;
        n_count        = r_count;
        out_load       = 1'b0;
        n_out_item.status           = STS_DONE;
        n_out_item.removed_value    = '0;
        n_out_item.removed_position = '0;
        n_out_item.occupancy        = '0;
        pos_ext        = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    out_load = 1'b1;
                    if (is_insert) begin
                        if (full) begin
                            n_out_item.status = STS_FULL;
                        end else begin
                            cell_ctl.op = (i_in_item.operation == OP_APPEND) ?
                                          CELL_APPEND : CELL_SORTED;
                            cell_pos    = r_count[IW-1:0];
                            n_count     = r_count + CW'(1);
                        end
                    end else if (empty) begin
                        n_out_item.status = STS_EMPTY;
                    end else if (i_in_item.operation == OP_REMOVE_FRONT) begin
                        cell_ctl.op = CELL_REMOVE;
                        cell_pos    = '0;
                        n_count     = r_count - CW'(1);
                        n_out_item.removed_value = w_entry[0];
                    end else begin
                        out_load        = 1'b0;
                        tok_start.valid = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    out_load    = 1'b1;
                    cell_ctl.op = CELL_REMOVE;
                    cell_pos    = w_tok_idx[DEPTH-1];
                    n_count     = r_count - CW'(1);
                    pos_ext     = PW'(w_tok_idx[DEPTH-1]);
                    n_out_item.removed_value    = w_tok[DEPTH-1].value;
                    n_out_item.removed_position = pos_ext[3:0];
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
        occ_ext = WW'(n_count);
        n_out_item.occupancy = occ_ext[4:0];
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [31:0] left_entry;
            logic signed [31:0] right_entry;
            logic               s_left;
            logic               s_right;
            t_tok               tok_in;
            logic [IW-1:0]      tok_idx_in;

            if (gi == 0) begin : g_first
                assign left_entry = i_in_item.value;
                assign s_left     = 1'b1;
                assign tok_in     = tok_start;
                assign tok_idx_in = '0;
            end else begin : g_mid
                assign left_entry = w_entry[gi-1];
                assign s_left     = w_s[gi-1];
                assign tok_in     = w_tok[gi-1];
                assign tok_idx_in = w_tok_idx[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign right_entry = w_entry[gi];
                assign s_right     = 1'b0;
            end else begin : g_inner
                assign right_entry = w_entry[gi+1];
                assign s_right     = w_s[gi+1];
            end

            bpq_cell #(
                .DEPTH (DEPTH),
                .IDX   (gi)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (cell_ctl),
                .i_pos         (cell_pos),
                .i_count       (r_count),
                .i_left_entry  (left_entry),
                .i_right_entry (right_entry),
                .i_s_left      (s_left),
                .i_s_right     (s_right),
                .o_s           (w_s[gi]),
                .o_entry       (w_entry[gi]),
                .i_tok         (tok_in),
                .i_tok_idx     (tok_idx_in),
                .o_tok         (w_tok[gi]),
                .o_tok_idx     (w_tok_idx[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item <= n_out_item;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= CAPACITY_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
                r_capacity <= pwdata[4:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

>>> src/bpq_cell.sv
`default_nettype none
module bpq_cell #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX   = 0
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bpq_pkg::t_cell_ctl             i_ctl,
    input  wire logic [$clog2(DEPTH)-1:0]       i_pos,
    input  wire logic [$clog2(DEPTH+1)-1:0]     i_count,
    input  wire logic signed [31:0]             i_left_entry,
    input  wire logic signed [31:0]             i_right_entry,
    input  wire logic                           i_s_left,
    input  wire logic                           i_s_right,
    output logic                                o_s,
    output logic signed [31:0]                  o_entry,
    input  wire bpq_pkg::t_tok                  i_tok,
    input  wire logic [$clog2(DEPTH)-1:0]       i_tok_idx,
    output bpq_pkg::t_tok                       o_tok,
    output logic [$clog2(DEPTH)-1:0]            o_tok_idx
);
    import bpq_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] MY_POS = IW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic signed [31:0] r_entry;
    logic signed [31:0] n_entry;
    t_tok               r_tok;
    t_tok               n_tok;
    logic [IW-1:0]      r_tok_idx;
    logic [IW-1:0]      n_tok_idx;
    logic               live;
    logic               le;
    logic               take;

    assign live    = MY_CNT < i_count;
    assign le      = live && (r_entry <= i_ctl.value);
    assign o_s     = le | i_s_right;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            CELL_SORTED: begin
                if (!i_s_left) begin
                    n_entry = i_left_entry;
                end else if (!o_s) begin
                    n_entry = i_ctl.value;
                end
            end
            CELL_APPEND: begin
                if (MY_POS == i_pos) begin
                    n_entry = i_ctl.value;
                end
            end
            CELL_REMOVE: begin
                if (MY_POS >= i_pos) begin
                    n_entry = i_right_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // take own entry if it beats the candidate handed in from the left
    assign take = i_tok.valid && live && (i_tok.none || (r_entry < i_tok.value));

    always_comb begin
        n_tok.valid = i_tok.valid;
        n_tok.none  = i_tok.none && !take;
        n_tok.value = take ? r_entry : i_tok.value;
        n_tok_idx   = take ? MY_POS : i_tok_idx;
    end

    always_ff @(posedge i_clk) begin
        r_entry   <= n_entry;
        r_tok.none  <= n_tok.none;
        r_tok.value <= n_tok.value;
        r_tok_idx <= n_tok_idx;
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;

endmodule
`default_nettype wire
